// ===== design/affine_warp_nearest_core_defines.svh =====
// ----------------------------------------------------------------------------
// affine_warp_nearest_core_defines.svh
// Assertion macros for the checker file of the affine warp core.
// ----------------------------------------------------------------------------
`ifndef AFFINE_WARP_NEAREST_CORE_DEFINES_SVH
`define AFFINE_WARP_NEAREST_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define AWN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("awn check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define AWN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("awn check failed");

`endif

// ===== design/awn_pkg.sv =====
// ----------------------------------------------------------------------------
// awn_pkg
// Types, sizes and helpers shared by the affine warp core modules.
// ----------------------------------------------------------------------------
`default_nettype none

package awn_pkg;

  // Frame geometry.
  localparam int IMG_WIDTH  = 256;
  localparam int IMG_HEIGHT = 256;
  localparam int XW         = $clog2(IMG_WIDTH);
  localparam int YW         = $clog2(IMG_HEIGHT);
  localparam int ADDR_W     = XW + YW;
  localparam int FRAME_DEPTH = 1 << ADDR_W;
  localparam int DIM_W      = 16;

  // Field widths.
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 8;
  localparam int COEF_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = COEF_W + COORD_W + 1;
  localparam int ACC_W      = PROD_W + 2;

  localparam logic [PIX_W-1:0] OUTSIDE_VALUE = PIX_W'(255);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_XX = 3'd0,
    CFG_COEF_XY = 3'd1,
    CFG_COEF_X0 = 3'd2,
    CFG_COEF_YX = 3'd3,
    CFG_COEF_YY = 3'd4,
    CFG_COEF_Y0 = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] xx;
    logic signed [COEF_W-1:0] xy;
    logic signed [COEF_W-1:0] x0;
    logic signed [COEF_W-1:0] yx;
    logic signed [COEF_W-1:0] yy;
    logic signed [COEF_W-1:0] y0;
  } awn_coef_t;

  // One frame access leaving the coordinate pipeline.
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic              in_bounds;
    logic              in_frame;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
  } awn_req_t;

  // Row-major frame address; rows are padded to a power of two.
  function automatic logic [ADDR_W-1:0] pix_addr(input logic [XW-1:0] x,
                                                 input logic [YW-1:0] y);
    return {y, x};
  endfunction

endpackage

`default_nettype wire

// ===== design/awn_coord.sv =====
// ----------------------------------------------------------------------------
// awn_coord
// Three-stage coordinate pipeline: products, Q27.16 sums, then truncation,
// frame range check and address selection.
// ----------------------------------------------------------------------------
`default_nettype none

module awn_coord
  import awn_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire op_t                in_op,
  input  wire logic [COORD_W-1:0] in_col,
  input  wire logic [COORD_W-1:0] in_row,
  input  wire logic [PIX_W-1:0]   in_pix,
  input  wire awn_coef_t          coef,
  input  wire logic               take,
  output awn_req_t                req
);

  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-(64'sd1 <<< FRAC_W));
  localparam logic signed [ACC_W-1:0] X_LIM  = ACC_W'(64'(IMG_WIDTH) << FRAC_W);
  localparam logic signed [ACC_W-1:0] Y_LIM  = ACC_W'(64'(IMG_HEIGHT) << FRAC_W);

  logic rdy1, rdy2, rdy3;

  // Stage 1: products.
  logic                     s1_valid_r;
  op_t                      s1_op_r;
  logic                     s1_in_frame_r;
  logic [ADDR_W-1:0]        s1_addr_r;
  logic [PIX_W-1:0]         s1_pix_r;
  logic signed [PROD_W-1:0] s1_p_xx_r, s1_p_xy_r, s1_p_yx_r, s1_p_yy_r;

  // Stage 2: sums.
  logic                     s2_valid_r;
  op_t                      s2_op_r;
  logic                     s2_in_frame_r;
  logic [ADDR_W-1:0]        s2_addr_r;
  logic [PIX_W-1:0]         s2_pix_r;
  logic signed [ACC_W-1:0]  s2_acc_x_r, s2_acc_y_r;

  // Stage 3: frame access.
  logic                     s3_valid_r;
  op_t                      s3_op_r;
  logic                     s3_inside_r;
  logic                     s3_in_frame_r;
  logic [ADDR_W-1:0]        s3_addr_r;
  logic [PIX_W-1:0]         s3_pix_r;

  logic signed [COORD_W:0]  col_s, row_s;
  logic                     in_frame_nxt;
  logic                     inside_x_nxt, inside_y_nxt;
  logic [XW-1:0]            sx_nxt;
  logic [YW-1:0]            sy_nxt;
  logic [ADDR_W-1:0]        addr_nxt;

  assign rdy3     = !s3_valid_r || take;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_ready = rdy1;

  assign col_s = {1'b0, in_col};
  assign row_s = {1'b0, in_row};

  assign in_frame_nxt = ({{(DIM_W-COORD_W){1'b0}}, in_col} < DIM_W'(IMG_WIDTH)) &&
                        ({{(DIM_W-COORD_W){1'b0}}, in_row} < DIM_W'(IMG_HEIGHT));

  // A sum in (-1.0, 0) truncates toward zero and so lands on coordinate 0.
  always_comb begin
    inside_x_nxt = (s2_acc_x_r > ACC_LO) && (s2_acc_x_r < X_LIM);
    inside_y_nxt = (s2_acc_y_r > ACC_LO) && (s2_acc_y_r < Y_LIM);
    sx_nxt = s2_acc_x_r[ACC_W-1] ? '0 : s2_acc_x_r[FRAC_W +: XW];
    sy_nxt = s2_acc_y_r[ACC_W-1] ? '0 : s2_acc_y_r[FRAC_W +: YW];
    addr_nxt = (s2_op_r == OP_READ) ? pix_addr(sx_nxt, sy_nxt) : s2_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r <= in_valid;
      if (rdy2) s2_valid_r <= s1_valid_r;
      if (rdy3) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_op_r       <= in_op;
      s1_in_frame_r <= in_frame_nxt;
      s1_addr_r     <= pix_addr(XW'(in_col), YW'(in_row));
      s1_pix_r      <= in_pix;
      s1_p_xx_r     <= coef.xx * col_s;
      s1_p_xy_r     <= coef.xy * row_s;
      s1_p_yx_r     <= coef.yx * col_s;
      s1_p_yy_r     <= coef.yy * row_s;
    end
    if (rdy2) begin
      s2_op_r       <= s1_op_r;
      s2_in_frame_r <= s1_in_frame_r;
      s2_addr_r     <= s1_addr_r;
      s2_pix_r      <= s1_pix_r;
      s2_acc_x_r    <= ACC_W'(s1_p_xx_r) + ACC_W'(s1_p_xy_r) + ACC_W'(coef.x0);
      s2_acc_y_r    <= ACC_W'(s1_p_yx_r) + ACC_W'(s1_p_yy_r) + ACC_W'(coef.y0);
    end
    if (rdy3) begin
      s3_op_r       <= s2_op_r;
      s3_inside_r   <= inside_x_nxt && inside_y_nxt;
      s3_in_frame_r <= s2_in_frame_r;
      s3_addr_r     <= addr_nxt;
      s3_pix_r      <= s2_pix_r;
    end
  end

  always_comb begin
    req.valid     = s3_valid_r;
    req.op        = s3_op_r;
    req.in_bounds = s3_inside_r;
    req.in_frame  = s3_in_frame_r;
    req.addr      = s3_addr_r;
    req.pix       = s3_pix_r;
  end

endmodule

`default_nettype wire

// ===== design/awn_frame_ram.sv =====
// ----------------------------------------------------------------------------
// awn_frame_ram
// Single-port source frame memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module awn_frame_ram
  import awn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [PIX_W-1:0]  wdata,
  output logic [PIX_W-1:0]       rdata
);

  logic [PIX_W-1:0] mem [FRAME_DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/affine_warp_nearest_core.sv =====
// ----------------------------------------------------------------------------
// affine_warp_nearest_core
// Inverse-mapped affine image warp with nearest-neighbor sampling.
// ----------------------------------------------------------------------------
// The core holds one 256 x 256 frame of 8-bit source pixels. A write word
// (in_tuser = 0) stores in_tdata pixel_in at (col, row) and gives no result.
// A read word (in_tuser = 1) maps the output coordinate (col, row) back into
// the source frame with six signed Q16.16 coefficients, truncates both sums
// toward zero, and returns one result word: the source pixel, or 255 with the
// outside flag set when the mapped point lies off the frame. The core takes
// one word per clock unless the output stalls. A word passes four register
// stages, the first of which loads at the accepting edge: one stage of four
// 32 x 9 multipliers, one stage of three-input sums, one stage of range
// check and address select, and the registered read of the frame memory.
// The frame memory has a single port and every word touches it in acceptance
// order at the same stage, so a read always sees all earlier writes and no
// bypass is needed. The frame is not cleared at reset; pixels must be written
// before they are sampled. The user must write coefficients on the cfg port
// only while no words are in flight; the core does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_warp_nearest_core
  import awn_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input stream.
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [23:0]          in_tdata,   // [7:0] col, [15:8] row, [23:16] pixel_in
  input  wire logic [0:0]           in_tuser,   // [0] op
  // Result stream.
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_tdata,  // [7:0] pixel_out
  output logic [0:0]                out_tuser,  // [0] outside
  // Coefficient writes.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data
);

  awn_coef_t        coef_r;
  awn_req_t         req;
  logic             take;
  logic             ram_wr_en;
  logic             ram_rd_en;
  logic [PIX_W-1:0] ram_rdata;
  logic             out_valid_r;
  logic             outside_r;

  // Coefficient registers. Indexes past the last register are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.xx <= COEF_W'(65536);
      coef_r.xy <= '0;
      coef_r.x0 <= '0;
      coef_r.yx <= '0;
      coef_r.yy <= COEF_W'(65536);
      coef_r.y0 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COEF_XX: coef_r.xx <= cfg_data;
        CFG_COEF_XY: coef_r.xy <= cfg_data;
        CFG_COEF_X0: coef_r.x0 <= cfg_data;
        CFG_COEF_YX: coef_r.yx <= cfg_data;
        CFG_COEF_YY: coef_r.yy <= cfg_data;
        CFG_COEF_Y0: coef_r.y0 <= cfg_data;
        default: ;
      endcase
    end
  end

  awn_coord u_coord (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (op_t'(in_tuser[0])),
    .in_col   (in_tdata[7:0]),
    .in_row   (in_tdata[15:8]),
    .in_pix   (in_tdata[23:16]),
    .coef     (coef_r),
    .take     (take),
    .req      (req)
  );

  // The last pipeline stage moves whenever the output register is free or
  // being drained. Writes retire here; reads fill the output register.
  assign take      = !out_valid_r || out_tready;
  assign ram_wr_en = req.valid && take && (req.op == OP_WRITE) && req.in_frame;
  assign ram_rd_en = req.valid && take && (req.op == OP_READ) && req.in_bounds;

  awn_frame_ram u_frame_ram (
    .clk   (clk),
    .wr_en (ram_wr_en),
    .rd_en (ram_rd_en),
    .addr  (req.addr),
    .wdata (req.pix),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= req.valid && (req.op == OP_READ);
    end
  end

  // The memory holds its read data while the output stalls, so only the
  // flag needs a register here.
  always_ff @(posedge clk) begin
    if (take) begin
      outside_r <= !req.in_bounds;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = outside_r ? OUTSIDE_VALUE : ram_rdata;
  assign out_tuser[0] = outside_r;

endmodule

`default_nettype wire

// ===== design/awn_checker.sv =====
// ----------------------------------------------------------------------------
// awn_checker
// Port-level checks on the affine warp core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "affine_warp_nearest_core_defines.svh"

module awn_checker
  import awn_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_tvalid,
  input wire logic                 in_tready,
  input wire logic [23:0]          in_tdata,
  input wire logic [0:0]           in_tuser,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [7:0]           out_tdata,
  input wire logic [0:0]           out_tuser,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [COEF_W-1:0]    cfg_data
);

  // A stalled result word keeps its value.
  `AWN_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // An off-frame sample always reads as white.
  `AWN_ASSERT_NOW(a_outside_white, out_tvalid && out_tuser[0], out_tdata == OUTSIDE_VALUE)

  // The input side only stalls when a result is waiting and not taken.
  `AWN_ASSERT_NOW(a_stall_cause, !in_tready, out_tvalid && !out_tready)

endmodule

bind affine_warp_nearest_core awn_checker u_awn_checker (.*);

`default_nettype wire

// ===== sim/tb_affine_warp_nearest_core.sv =====
// ----------------------------------------------------------------------------
// tb_affine_warp_nearest_core
// Self-checking testbench for the affine warp nearest-neighbor core.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the six Q16.16 coefficients and of the
// 256 x 256 source frame. Every accepted read word is mapped back into the
// source frame with 64-bit sums truncated toward zero, and the pixel it
// should return is queued. A monitor compares every result word, field by
// field, with the oldest queued pixel. Directed tests cover the frame
// corners, sums with a small negative fraction, the coefficient extremes,
// writes to the unused register indexes and a long output stall. Random
// phases then run several warp families with mixed writes and reads, while
// the sender bursts and the receiver stalls on patterns of their own.
// A read never samples a pixel that was not written first: when a read maps
// onto an unwritten pixel, a write of a random value to that pixel goes out
// just ahead of it.
// ----------------------------------------------------------------------------

module tb_affine_warp_nearest_core;
  timeunit 1ns;
  timeprecision 1ps;

  import awn_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 4;
  // Writes give no result, so the bench lets the pipeline settle after the last
  // read has returned before the core is treated as idle.
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int RUN_LIMIT_NS  = 5_000_000;
  localparam int MAX_REPORTS   = 40;
  localparam int Q_ONE         = 1 << FRAC_W;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_WORDS   = 160;
  localparam int HOLD_CYCLES   = 240;

  // Register indexes past the last coefficient; the core must ignore them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             outside;
  } warp_sample_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    data;
  } reg_write_t;

  typedef enum {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_ALTERNATE
  } rx_mode_t;

  typedef enum {
    WARP_NEAR_IDENTITY,
    WARP_ANY,
    WARP_ZOOM,
    WARP_ROTATE90
  } warp_family_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;   // [7:0] col, [15:8] row, [23:16] pixel_in
  logic [0:0]           in_tuser;   // [0] op
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;  // [7:0] pixel_out
  logic [0:0]           out_tuser;  // [0] outside
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  // Bench copy of the core state.
  int           coef_now [6];
  logic [7:0]   frame_px [FRAME_DEPTH];
  bit           frame_seen [FRAME_DEPTH];

  warp_sample_t expected_px_q [$];
  reg_write_t   reg_writes_q [$];
  warp_sample_t due_sample;
  int           err_count;

  // Sender burst control.
  bit           tx_gaps_on;
  int           tx_burst_left;

  // Receiver stall control.
  int           rx_hold_req;
  int           rx_hold_left;
  rx_mode_t     rx_mode;
  int           rx_mode_left;
  bit           rx_phase;

  affine_warp_nearest_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Drop the fraction bits of a Q16.16 sum, rounding toward zero.
  function automatic longint drop_fraction(input longint acc);
    if (acc >= 0) return acc >>> FRAC_W;
    return -((-acc) >>> FRAC_W);
  endfunction

  function automatic longint project_axis(input int w_col, input int w_row, input int w_off,
                                          input logic [COORD_W-1:0] col,
                                          input logic [COORD_W-1:0] row);
    return drop_fraction(longint'(w_col) * longint'(col) + longint'(w_row) * longint'(row)
                         + longint'(w_off));
  endfunction

  // Frame slot that output (col, row) samples, or -1 when it lies off frame.
  function automatic int source_slot(input logic [COORD_W-1:0] col,
                                     input logic [COORD_W-1:0] row);
    longint sx;
    longint sy;
    sx = project_axis(coef_now[CFG_COEF_XX], coef_now[CFG_COEF_XY], coef_now[CFG_COEF_X0],
                      col, row);
    sy = project_axis(coef_now[CFG_COEF_YX], coef_now[CFG_COEF_YY], coef_now[CFG_COEF_Y0],
                      col, row);
    if (sx < 0 || sx >= IMG_WIDTH || sy < 0 || sy >= IMG_HEIGHT) return -1;
    return int'(sy) * IMG_WIDTH + int'(sx);
  endfunction

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // --------------------------------------------------------------------------
  // Result monitor: each accepted result word is checked against the oldest
  // pending read.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_px_q.size() == 0) begin
        if (err_count < MAX_REPORTS)
          $display("%0t ns: result word with no read pending: expected none, actual pixel %0d outside %0b",
                   $time, out_tdata, out_tuser[0]);
        err_count++;
      end else begin
        due_sample = expected_px_q.pop_front();
        if (out_tdata !== due_sample.pixel) begin
          if (err_count < MAX_REPORTS)
            $display("%0t ns: pixel_out mismatch: expected %0d, actual %0d",
                     $time, due_sample.pixel, out_tdata);
          err_count++;
        end
        if (out_tuser[0] !== due_sample.outside) begin
          if (err_count < MAX_REPORTS)
            $display("%0t ns: outside flag mismatch: expected %0b, actual %0b",
                     $time, due_sample.outside, out_tuser[0]);
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: a long hold when a test asks for one, otherwise a stall
  // pattern that is redrawn after a random stretch. The plain streaming mode
  // gives stretches without any stall.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(16, 160);
      end
      rx_mode_left--;
      rx_phase = ~rx_phase;
      case (rx_mode)
        RX_STREAM:    out_tready <= 1'b1;
        RX_COIN:      out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE:    out_tready <= ($urandom_range(0, 3) == 0);
        RX_ALTERNATE: out_tready <= rx_phase;
        default:      out_tready <= 1'b1;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks. All of them start and end at a falling edge.
  // --------------------------------------------------------------------------

  // Send one input word. When bursts are on, a random gap ends each burst.
  // The model is updated at the edge where the word is accepted, and valid
  // stays high on return so that back-to-back words go out without a gap.
  task automatic send_word(input op_t op, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic [PIX_W-1:0] pix);
    int           slot;
    warp_sample_t want;
    if (tx_gaps_on && tx_burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
      tx_burst_left = $urandom_range(1, 24);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {pix, row, col};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    if (op == OP_WRITE) begin
      slot             = int'(row) * IMG_WIDTH + int'(col);
      frame_px[slot]   = pix;
      frame_seen[slot] = 1'b1;
    end else begin
      slot = source_slot(col, row);
      if (slot < 0) begin
        want.pixel   = OUTSIDE_VALUE;
        want.outside = 1'b1;
      end else begin
        want.pixel   = frame_px[slot];
        want.outside = 1'b0;
      end
      expected_px_q.push_back(want);
    end
    @(negedge clk);
  endtask

  // Read the output pixel at (col, row). An unwritten source pixel is
  // written with a random value first.
  task automatic read_output(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    int slot;
    slot = source_slot(col, row);
    if (slot >= 0 && !frame_seen[slot])
      send_word(OP_WRITE, COORD_W'(slot % IMG_WIDTH), COORD_W'(slot / IMG_WIDTH),
                PIX_W'($urandom));
    send_word(OP_READ, col, row, PIX_W'($urandom));
  endtask

  // Stop sending and wait until every read has returned, then let the last
  // writes leave the pipeline.
  task automatic drain_pipeline();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (expected_px_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_coefs(input int xx, input int xy, input int x0,
                             input int yx, input int yy, input int y0);
    reg_writes_q.push_back({CFG_COEF_XX, COEF_W'(xx)});
    reg_writes_q.push_back({CFG_COEF_XY, COEF_W'(xy)});
    reg_writes_q.push_back({CFG_COEF_X0, COEF_W'(x0)});
    reg_writes_q.push_back({CFG_COEF_YX, COEF_W'(yx)});
    reg_writes_q.push_back({CFG_COEF_YY, COEF_W'(yy)});
    reg_writes_q.push_back({CFG_COEF_Y0, COEF_W'(y0)});
  endtask

  // Write all queued registers once the core is idle.
  task automatic apply_regs();
    reg_write_t w;
    drain_pipeline();
    while (reg_writes_q.size() != 0) begin
      w = reg_writes_q.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.data;
      do @(posedge clk); while (!cfg_ready);
      case (w.idx)
        CFG_COEF_XX, CFG_COEF_XY, CFG_COEF_X0,
        CFG_COEF_YX, CFG_COEF_YY, CFG_COEF_Y0: coef_now[w.idx] = int'(w.data);
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset coefficients map every output pixel onto itself. The corners are
  // written with the extreme pixel values and read back.
  task automatic test_identity_corners();
    send_word(OP_WRITE, 8'd0,   8'd0,   8'h00);
    send_word(OP_WRITE, 8'd255, 8'd255, 8'hFF);
    send_word(OP_WRITE, 8'd255, 8'd0,   8'hAA);
    send_word(OP_WRITE, 8'd0,   8'd255, 8'h55);
    read_output(8'd0,   8'd0);
    read_output(8'd255, 8'd255);
    read_output(8'd255, 8'd0);
    read_output(8'd0,   8'd255);
  endtask

  // A sum just below zero truncates to zero and stays inside; a sum of
  // exactly minus one falls off the frame.
  task automatic test_negative_fraction();
    queue_coefs(Q_ONE, 0, -1, 0, Q_ONE, -(Q_ONE - 1));
    apply_regs();
    read_output(8'd0, 8'd0);
    read_output(8'd5, 8'd3);
    queue_coefs(Q_ONE, 0, -Q_ONE, 0, Q_ONE, 0);
    apply_regs();
    read_output(8'd0, 8'd0);
    read_output(8'd1, 8'd7);
  endtask

  // Largest and smallest coefficients in every register, then a constant
  // map whose offsets carry a full fraction.
  task automatic test_coef_extremes();
    queue_coefs(int'(32'h7FFF_FFFF), int'(32'h7FFF_FFFF), int'(32'h7FFF_FFFF),
                int'(32'h7FFF_FFFF), int'(32'h7FFF_FFFF), int'(32'h7FFF_FFFF));
    apply_regs();
    read_output(8'd0,   8'd0);
    read_output(8'd255, 8'd255);
    queue_coefs(int'(32'h8000_0000), int'(32'h8000_0000), int'(32'h8000_0000),
                int'(32'h8000_0000), int'(32'h8000_0000), int'(32'h8000_0000));
    apply_regs();
    read_output(8'd0,   8'd0);
    read_output(8'd255, 8'd0);
    queue_coefs(0, 0, 255 * Q_ONE + (Q_ONE - 1), 0, 0, Q_ONE - 1);
    apply_regs();
    read_output(8'd17,  8'd200);
    read_output(8'd255, 8'd255);
  endtask

  // Writes to the indexes past the coefficients must leave them untouched.
  task automatic test_spare_index();
    queue_coefs(Q_ONE, 0, 0, 0, Q_ONE, 0);
    reg_writes_q.push_back({CFG_SPARE_6, COEF_W'($urandom)});
    reg_writes_q.push_back({CFG_SPARE_7, COEF_W'($urandom)});
    apply_regs();
    read_output(8'd255, 8'd255);
    read_output(8'd0,   8'd255);
  endtask

  // The receiver holds off for a long stretch while reads keep coming at
  // full rate, so the core fills up and must stall its input.
  task automatic test_output_hold();
    queue_coefs(Q_ONE, 0, 0, 0, Q_ONE, 0);
    apply_regs();
    tx_gaps_on  = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    for (int n = 0; n < 64; n++)
      read_output(COORD_W'($urandom_range(0, 15)), COORD_W'($urandom_range(0, 15)));
    tx_gaps_on = 1'b1;
  endtask

  task automatic queue_random_warp(input warp_family_t fam);
    case (fam)
      WARP_NEAR_IDENTITY:
        queue_coefs(Q_ONE + span(-Q_ONE / 2, Q_ONE / 2), span(-Q_ONE / 3, Q_ONE / 3),
                    span(-48 * Q_ONE, 48 * Q_ONE), span(-Q_ONE / 3, Q_ONE / 3),
                    Q_ONE + span(-Q_ONE / 2, Q_ONE / 2), span(-48 * Q_ONE, 48 * Q_ONE));
      WARP_ANY:
        queue_coefs(int'($urandom), int'($urandom), int'($urandom),
                    int'($urandom), int'($urandom), int'($urandom));
      WARP_ZOOM:
        queue_coefs(span(-4 * Q_ONE, 4 * Q_ONE), span(-Q_ONE / 4, Q_ONE / 4),
                    span(-256 * Q_ONE, 512 * Q_ONE), span(-Q_ONE / 4, Q_ONE / 4),
                    span(-4 * Q_ONE, 4 * Q_ONE), span(-256 * Q_ONE, 512 * Q_ONE));
      default:
        // Quarter turn: source x follows the output row, source y runs
        // against the output column.
        queue_coefs(0, Q_ONE, span(0, Q_ONE - 1),
                    -Q_ONE, 0, 255 * Q_ONE + span(0, Q_ONE - 1));
    endcase
  endtask

  // One random word: mostly reads, part of them near the origin so that
  // they often land on pixels written earlier.
  task automatic random_word();
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    bit                 near_origin;
    near_origin = ($urandom_range(0, 9) < 4);
    col = near_origin ? COORD_W'($urandom_range(0, 15)) : COORD_W'($urandom);
    row = near_origin ? COORD_W'($urandom_range(0, 15)) : COORD_W'($urandom);
    if ($urandom_range(0, 99) < 30)
      send_word(OP_WRITE, col, row, PIX_W'($urandom));
    else
      read_output(col, row);
  endtask

  task automatic test_random_warps();
    warp_family_t fam;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      fam = (ph < 4) ? warp_family_t'(ph) : warp_family_t'($urandom_range(0, 3));
      queue_random_warp(fam);
      apply_regs();
      // One phase runs with the sender never pausing.
      tx_gaps_on = (ph != 2);
      for (int n = 0; n < PHASE_WORDS; n++) random_word();
      tx_gaps_on = 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    err_count     = 0;
    tx_gaps_on    = 1'b1;
    tx_burst_left = 0;
    rx_hold_req   = 0;
    rx_hold_left  = 0;
    rx_mode       = RX_STREAM;
    rx_mode_left  = 0;
    rx_phase      = 1'b0;
    coef_now[CFG_COEF_XX] = Q_ONE;
    coef_now[CFG_COEF_XY] = 0;
    coef_now[CFG_COEF_X0] = 0;
    coef_now[CFG_COEF_YX] = 0;
    coef_now[CFG_COEF_YY] = Q_ONE;
    coef_now[CFG_COEF_Y0] = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_identity_corners();
    test_negative_fraction();
    test_coef_extremes();
    test_spare_index();
    test_output_hold();
    test_random_warps();

    drain_pipeline();
    if (expected_px_q.size() != 0) begin
      $display("%0t ns: read results missing: expected %0d more, actual 0",
               $time, expected_px_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop in case the core hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
